FILE: src/tsd_pkg.sv
// Shared types and constants of the tar stream deframer.
// No dependencies; every other file of the block imports this package.
package tsd_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int OFF_W         = $clog2(BLOCK_BYTES);
    localparam int ENTRY_SIZE_W  = 36;
    localparam int SIZE_BITS     = 36;
    localparam int LIMIT_W       = 64;
    localparam int RSUM_W        = 17;
    localparam int SSUM_W        = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Header field offsets.
    localparam logic [OFF_W-1:0] OFF_SIZE_FIRST  = OFF_W'(124);
    localparam logic [OFF_W-1:0] OFF_SIZE_LAST   = OFF_W'(135);
    localparam logic [OFF_W-1:0] OFF_SUM_FIRST   = OFF_W'(148);
    localparam logic [OFF_W-1:0] OFF_SUM_LAST    = OFF_W'(155);
    localparam logic [OFF_W-1:0] OFF_TYPE        = OFF_W'(156);
    localparam logic [OFF_W-1:0] OFF_MAGIC_FIRST = OFF_W'(257);
    localparam logic [OFF_W-1:0] OFF_MAGIC_LAST  = OFF_W'(261);
    localparam logic [OFF_W-1:0] OFF_BLOCK_LAST  = OFF_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LNAME  = 8'h4C;   // 'L'
    localparam logic [7:0] CHAR_LLINK  = 8'h4B;   // 'K'

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_LNAME  = 3'd2,
        KIND_LLINK  = 3'd3,
        KIND_REJECT = 3'd4
    } kind_t;

    // One result on its way from the parser to the output stage.
    typedef struct packed {
        logic [2:0]              kind;
        logic [7:0]              payload_byte;
        logic [ENTRY_SIZE_W-1:0] entry_size;
        logic [7:0]              entry_type;
        logic                    last_of_run;
    } rec_t;

    // Queue status seen by the top level and the output stage.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: src/tsd_front.sv
// Parser front end: accepts archive bytes, tracks the entry phase, checks
// headers and builds result requests. Depends on tsd_pkg.
module tsd_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    output logic         push,
    output tsd_pkg::rec_t rec
);
    import tsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DATA,
        PH_LNAME,
        PH_LLINK,
        PH_PAD
    } phase_t;

    typedef struct packed {
        logic size_stop;
        logic sum_stop;
        logic nul_sum;
        logic magic_ok;
    } hdr_flags_t;

    localparam logic [LIMIT_W-1:0] SIZE_LIMIT = {LIMIT_W{1'b1}} >> (LIMIT_W - SIZE_BITS);

    phase_t                    phase_reg, phase_next;
    logic [OFF_W-1:0]          off_reg, off_next;
    logic [ENTRY_SIZE_W-1:0]   left_reg, left_next;
    logic [OFF_W-1:0]          pad_reg, pad_next;
    logic [RSUM_W-1:0]         rsum_reg, rsum_next;
    logic [SSUM_W-1:0]         ssum_reg, ssum_next;
    logic [ENTRY_SIZE_W-1:0]   psize_reg, psize_next;
    logic [7:0]                type_reg, type_next;
    hdr_flags_t                flags_reg, flags_next;

    logic                      first;
    logic                      octal;
    logic                      in_sum_field;
    logic                      in_size_field;
    logic [2:0]                magic_idx;
    logic [ENTRY_SIZE_W-1:0]   size_sat;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;   // u
            3'd1:    c = 8'h73;   // s
            3'd2:    c = 8'h74;   // t
            3'd3:    c = 8'h61;   // a
            3'd4:    c = 8'h72;   // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign first         = (off_reg == '0);
    assign octal         = (data_byte[7:3] == 5'b00110);
    assign in_sum_field  = (off_reg >= OFF_SUM_FIRST) && (off_reg <= OFF_SUM_LAST);
    assign in_size_field = (off_reg >= OFF_SIZE_FIRST) && (off_reg <= OFF_SIZE_LAST);
    assign magic_idx     = 3'(off_reg - OFF_MAGIC_FIRST);
    assign size_sat      = ({{(LIMIT_W-ENTRY_SIZE_W){1'b0}}, psize_reg} > SIZE_LIMIT)
                           ? SIZE_LIMIT[ENTRY_SIZE_W-1:0] : psize_reg;

    always_comb
    begin
        phase_next = phase_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        pad_next   = pad_reg;
        rsum_next  = rsum_reg;
        ssum_next  = ssum_reg;
        psize_next = psize_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        push       = 1'b0;
        rec        = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_DATA, PH_LNAME, PH_LLINK:
                begin
                    push             = 1'b1;
                    rec.kind         = (phase_reg == PH_DATA)  ? KIND_DATA :
                                       (phase_reg == PH_LNAME) ? KIND_LNAME : KIND_LLINK;
                    rec.payload_byte = data_byte;
                    left_next        = left_reg - ENTRY_SIZE_W'(1);
                    if (left_reg == ENTRY_SIZE_W'(1))
                    begin
                        rec.last_of_run = 1'b1;
                        phase_next      = (pad_reg != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - OFF_W'(1);
                    if (pad_reg == OFF_W'(1))
                        phase_next = PH_HEADER;
                end
                default:
                begin
                    // Header byte. Offset zero starts a fresh header.
                    if (first)
                    begin
                        flags_next = '{size_stop: 1'b0, sum_stop: 1'b0,
                                       nul_sum: 1'b0, magic_ok: 1'b1};
                        ssum_next  = '0;
                        psize_next = '0;
                        type_next  = '0;
                    end
                    rsum_next = (first ? '0 : rsum_reg) +
                                (in_sum_field ? RSUM_W'(32) : RSUM_W'(data_byte));

                    if (in_size_field && !flags_reg.size_stop)
                    begin
                        if (octal)
                            psize_next = {psize_reg[ENTRY_SIZE_W-4:0], data_byte[2:0]};
                        else if (!(data_byte == CHAR_SPACE && psize_reg == '0))
                            flags_next.size_stop = 1'b1;
                    end
                    if (in_sum_field)
                    begin
                        if (off_reg == OFF_SUM_FIRST && data_byte == CHAR_NUL)
                            flags_next.nul_sum = 1'b1;
                        if (!flags_reg.sum_stop)
                        begin
                            if (octal)
                                ssum_next = {ssum_reg[SSUM_W-4:0], data_byte[2:0]};
                            else if (!(data_byte == CHAR_SPACE && ssum_reg == '0))
                                flags_next.sum_stop = 1'b1;
                        end
                    end
                    if (off_reg == OFF_TYPE)
                        type_next = data_byte;
                    if (off_reg >= OFF_MAGIC_FIRST && off_reg <= OFF_MAGIC_LAST &&
                        data_byte != magic_char(magic_idx))
                        flags_next.magic_ok = 1'b0;

                    off_next   = off_reg + OFF_W'(1);
                    phase_next = PH_HEADER;

                    // The last byte of the block lies in no field, so the
                    // verdict uses the stored fields and the updated sum.
                    if (off_reg == OFF_BLOCK_LAST && !flags_reg.nul_sum)
                    begin
                        if ({{(SSUM_W-RSUM_W){1'b0}}, rsum_next} != ssum_reg ||
                            !flags_reg.magic_ok)
                        begin
                            push     = 1'b1;
                            rec.kind = KIND_REJECT;
                        end
                        else
                        begin
                            left_next = size_sat;
                            pad_next  = OFF_W'(0) - size_sat[OFF_W-1:0];
                            if (type_reg == CHAR_LNAME || type_reg == CHAR_LLINK)
                            begin
                                if (size_sat != '0)
                                    phase_next = (type_reg == CHAR_LNAME) ? PH_LNAME
                                                                          : PH_LLINK;
                            end
                            else
                            begin
                                push           = 1'b1;
                                rec.kind       = KIND_ACCEPT;
                                rec.entry_size = size_sat;
                                rec.entry_type = type_reg;
                                if (size_sat != '0)
                                    phase_next = PH_DATA;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg   <= '0;
            left_reg  <= '0;
            pad_reg   <= '0;
            rsum_reg  <= '0;
            ssum_reg  <= '0;
            psize_reg <= '0;
            type_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            left_reg  <= left_next;
            pad_reg   <= pad_next;
            rsum_reg  <= rsum_next;
            ssum_reg  <= ssum_next;
            psize_reg <= psize_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: src/tsd_queue.sv
// Short result queue between the parser and the output stage.
// Depends on tsd_pkg for the result record and status types.
module tsd_queue #(
    parameter int DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tsd_pkg::rec_t         push_rec,
    input  logic                  pop,
    output tsd_pkg::rec_t         pop_rec,
    output tsd_pkg::queue_status_t status
);
    import tsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_rec      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

FILE: src/tsd_out.sv
// Output stage: pulls requests from the queue into the result register
// and presents them on the result channel. Depends on tsd_pkg.
module tsd_out (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsd_pkg::queue_status_t status,
    input  tsd_pkg::rec_t          head_rec,
    output logic                   pop,
    input  logic                   res_stall,
    output logic                   res_valid,
    output tsd_pkg::rec_t          res_rec
);
    import tsd_pkg::*;

    logic valid_reg, valid_next;
    rec_t rec_reg;

    // Refill whenever the register is empty or its request is taken now.
    assign pop        = !status.empty && (!valid_reg || !res_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && res_stall);
    assign res_valid  = valid_reg;
    assign res_rec    = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= head_rec;
    end

endmodule

FILE: src/tar_stream_deframer.sv
// Top level of the tar stream deframer: parser, result queue and output stage.
// Depends on tsd_pkg, tsd_front, tsd_queue and tsd_out.
//
//   Channel   Direction  Handshake                  Payload
//   byte      in         byte_valid / byte_stall    data_byte
//   res       out        res_valid / res_stall      kind, payload_byte, entry_size,
//                                                   entry_type, last_of_run
//
// One archive byte is taken per cycle unless stalled; the parser decides
// each byte in the cycle it arrives; results go via the queue and result register.
// The input stalls only while the result queue (QUEUE_DEPTH entries) is full.
// Reset puts the parser at the start of a header block and empties the queue.
// A stall on the result side holds the result register; the queue absorbs
// up to QUEUE_DEPTH further results before the input stalls.
module tar_stream_deframer #(
    parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [7:0]                        data_byte,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [2:0]                        kind,
    output logic [7:0]                        payload_byte,
    output logic [tsd_pkg::ENTRY_SIZE_W-1:0]  entry_size,
    output logic [7:0]                        entry_type,
    output logic                              last_of_run
);
    import tsd_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    rec_t          push_rec;
    rec_t          head_rec;
    rec_t          res_rec;
    queue_status_t status;

    assign byte_stall = status.full;
    assign accept     = byte_valid && !status.full;

    tsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .push      (push),
        .rec       (push_rec)
    );

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (head_rec),
        .status   (status)
    );

    tsd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .head_rec  (head_rec),
        .pop       (pop),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_rec   (res_rec)
    );

    assign kind         = res_rec.kind;
    assign payload_byte = res_rec.payload_byte;
    assign entry_size   = res_rec.entry_size;
    assign entry_type   = res_rec.entry_type;
    assign last_of_run  = res_rec.last_of_run;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench of tar_stream_deframer: streams directed and random tar archive entries
// through the byte channel and checks every result against a cycle-free model.
// Depends on tsd_pkg and the RTL of the block.
module tb;
    import tsd_pkg::*;

    typedef enum int {
        HS_GOOD, HS_BADSUM, HS_BADMAGIC, HS_CORRUPT, HS_NULSUM, HS_ZERO, HS_NOISE
    } hdr_style_t;

    typedef enum int { SF_STD, SF_SPACE, SF_JUNK, SF_FULL } size_form_t;

    typedef enum int { ST_HDR, ST_FILE, ST_LNAME, ST_LLINK, ST_PAD } stage_t;

    typedef struct {
        hdr_style_t  style;
        logic [7:0]  tchar;
        logic [35:0] size;
        size_form_t  form;
        bit          typed;
        bit          has;
        kind_t       kd;
    } entry_row_t;

    typedef struct {
        logic [7:0] data;
        bit         hold;
        bit         typed;
        bit         typed_has;
        rec_t       typed_rec;
    } arch_item_t;

    localparam logic [7:0]  CH_REGULAR  = 8'h30;   // '0'
    localparam logic [7:0]  CH_FOLDER   = 8'h35;   // '5'
    localparam logic [7:0]  CHAR_DIGIT0 = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [39:0] USTAR_TEXT  = "ustar";
    localparam int          SUM_BLANKS  = 8 * 32;
    localparam int          RANDOM_BYTES = 1850;
    localparam int          RANDOM_ENTRIES = 10;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    byte_valid = 1'b0;
    logic                    byte_stall;
    logic [7:0]              data_byte = 8'h00;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic [2:0]              kind;
    logic [7:0]              payload_byte;
    logic [ENTRY_SIZE_W-1:0] entry_size;
    logic [7:0]              entry_type;
    logic                    last_of_run;

    tar_stream_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .entry_size   (entry_size),
        .entry_type   (entry_type),
        .last_of_run  (last_of_run)
    );

    // Deframer model state.
    stage_t      stage = ST_HDR;
    logic [8:0]  hoff = '0;
    logic [35:0] body_left = '0;
    logic [36:0] to_boundary = '0;
    logic [16:0] hsum = '0;
    logic [23:0] field_sum = '0;
    logic [35:0] field_size = '0;
    logic [7:0]  tflag = '0;
    bit          magic_ok, sum_empty, sum_done, size_done;

    arch_item_t  stim[$];
    rec_t        expected_q[$];
    logic [7:0]  hdr_blk [BLOCK_BYTES];
    entry_row_t  dir_rows [17];

    int unsigned taken = 0;
    int unsigned errors = 0;
    int unsigned n_accept = 0;
    int unsigned n_reject = 0;
    int unsigned n_payload = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // The size is masked to 36 bits while it is parsed, so it can never exceed the
    // saturation limit of a 36-bit size.
    function automatic bit deframe_byte(input logic [7:0] b, output rec_t r);
        logic [8:0] pad;
        int         k;
        r = '0;
        case (stage)
            ST_FILE, ST_LNAME, ST_LLINK:
            begin
                r.kind = (stage == ST_FILE) ? KIND_DATA :
                         (stage == ST_LNAME) ? KIND_LNAME : KIND_LLINK;
                r.payload_byte = b;
                body_left = body_left - 1'b1;
                to_boundary = to_boundary - 1'b1;
                if (body_left == 0)
                begin
                    r.last_of_run = 1'b1;
                    stage = (to_boundary != 0) ? ST_PAD : ST_HDR;
                    hoff = '0;
                end
                return 1'b1;
            end
            ST_PAD:
            begin
                to_boundary = to_boundary - 1'b1;
                if (to_boundary == 0)
                begin
                    stage = ST_HDR;
                    hoff = '0;
                end
                return 1'b0;
            end
            default: stage = ST_HDR;
        endcase

        if (hoff == 0)
        begin
            magic_ok = 1'b1;
            sum_empty = 1'b0;
            sum_done = 1'b0;
            size_done = 1'b0;
            hsum = '0;
            field_sum = '0;
            field_size = '0;
            tflag = '0;
        end
        hsum = hsum + ((hoff >= OFF_SUM_FIRST && hoff <= OFF_SUM_LAST) ? 17'd32 : 17'(b));

        // An octal digit is 0x30..0x37; a space is skipped only before any value.
        if (hoff >= OFF_SIZE_FIRST && hoff <= OFF_SIZE_LAST && !size_done)
        begin
            if (b[7:3] == 5'b00110)
                field_size = {field_size[32:0], b[2:0]};
            else if (!(b == CHAR_SPACE && field_size == 0))
                size_done = 1'b1;
        end
        if (hoff >= OFF_SUM_FIRST && hoff <= OFF_SUM_LAST)
        begin
            if (hoff == OFF_SUM_FIRST && b == CHAR_NUL)
                sum_empty = 1'b1;
            if (!sum_done)
            begin
                if (b[7:3] == 5'b00110)
                    field_sum = {field_sum[20:0], b[2:0]};
                else if (!(b == CHAR_SPACE && field_sum == 0))
                    sum_done = 1'b1;
            end
        end
        if (hoff == OFF_TYPE)
            tflag = b;
        if (hoff >= OFF_MAGIC_FIRST && hoff <= OFF_MAGIC_LAST)
        begin
            k = int'(hoff - OFF_MAGIC_FIRST);
            if (b != USTAR_TEXT[8*(4-k) +: 8])
                magic_ok = 1'b0;
        end

        if (hoff != OFF_BLOCK_LAST)
        begin
            hoff = hoff + 1'b1;
            return 1'b0;
        end
        hoff = '0;

        if (sum_empty)
            return 1'b0;
        if (24'(hsum) != field_sum || !magic_ok)
        begin
            r.kind = KIND_REJECT;
            return 1'b1;
        end

        pad = 9'd0 - field_size[8:0];
        if (tflag == CHAR_LNAME || tflag == CHAR_LLINK)
        begin
            if (field_size == 0)
                return 1'b0;
            body_left = field_size;
            to_boundary = 37'(field_size) + 37'(pad);
            stage = (tflag == CHAR_LNAME) ? ST_LNAME : ST_LLINK;
            return 1'b0;
        end

        r.kind = KIND_ACCEPT;
        r.entry_size = field_size;
        r.entry_type = tflag;
        if (field_size != 0)
        begin
            body_left = field_size;
            to_boundary = 37'(field_size) + 37'(pad);
            stage = ST_FILE;
        end
        return 1'b1;
    endfunction

    function automatic void put_octal(int at, int digits, logic [63:0] v);
        int k;
        for (k = 0; k < digits; k++)
            hdr_blk[at + digits - 1 - k] = CHAR_DIGIT0 + 8'(v[3*k +: 3]);
    endfunction

    function automatic void emit(logic [7:0] d);
        arch_item_t it;
        it.data = d;
        it.hold = 1'b0;
        it.typed = 1'b0;
        it.typed_has = 1'b0;
        it.typed_rec = '0;
        stim.push_back(it);
    endfunction

    // Appends one header block and, for a good header when with_body is set, its body and padding.
    function automatic void add_entry(hdr_style_t style, logic [7:0] tch, logic [35:0] size,
                                      size_form_t form, bit typed, bit has, kind_t kd,
                                      bit with_body);
        int          i;
        int          pos;
        int unsigned csum;
        logic [8:0]  pad;
        logic [63:0] n;
        rec_t        tr;
        for (i = 0; i < BLOCK_BYTES; i++)
        begin
            if (style == HS_NOISE)
                hdr_blk[i] = 8'($urandom);
            else if (style == HS_ZERO || $urandom_range(0, 3) != 0)
                hdr_blk[i] = 8'h00;
            else
                hdr_blk[i] = 8'($urandom);
        end

        if (style != HS_NOISE && style != HS_ZERO)
        begin
            case (form)
                SF_STD:
                begin
                    put_octal(OFF_SIZE_FIRST, 11, 64'(size));
                    hdr_blk[OFF_SIZE_LAST] = CHAR_NUL;
                end
                SF_SPACE:
                begin
                    for (i = 0; i < 3; i++)
                        hdr_blk[OFF_SIZE_FIRST + i] = CHAR_SPACE;
                    put_octal(OFF_SIZE_FIRST + 3, 8, 64'(size));
                    hdr_blk[OFF_SIZE_LAST] = CHAR_SPACE;
                end
                SF_JUNK:
                begin
                    // A non-octal character ends the field; the digits after it are ignored.
                    put_octal(OFF_SIZE_FIRST, 8, 64'(size));
                    hdr_blk[OFF_SIZE_FIRST + 8] = CHAR_NINE;
                    put_octal(OFF_SIZE_FIRST + 9, 3, 64'($urandom_range(0, 511)));
                end
                default: put_octal(OFF_SIZE_FIRST, 12, 64'(size));
            endcase
            hdr_blk[OFF_TYPE] = tch;
            for (i = 0; i < 5; i++)
                hdr_blk[OFF_MAGIC_FIRST + i] = USTAR_TEXT[8*(4-i) +: 8];
            if (style == HS_BADMAGIC)
            begin
                pos = $urandom_range(0, 4);
                hdr_blk[OFF_MAGIC_FIRST + pos] ^= 8'($urandom_range(1, 255));
            end

            csum = SUM_BLANKS;
            for (i = 0; i < BLOCK_BYTES; i++)
                if (i < OFF_SUM_FIRST || i > OFF_SUM_LAST)
                    csum += hdr_blk[i];
            if (style == HS_BADSUM)
                csum += $urandom_range(1, 7);
            case ($urandom_range(0, 2))
                0:
                begin
                    put_octal(OFF_SUM_FIRST, 6, 64'(csum));
                    hdr_blk[OFF_SUM_FIRST + 6] = CHAR_NUL;
                    hdr_blk[OFF_SUM_LAST] = CHAR_SPACE;
                end
                1:
                begin
                    hdr_blk[OFF_SUM_FIRST] = CHAR_SPACE;
                    put_octal(OFF_SUM_FIRST + 1, 6, 64'(csum));
                    hdr_blk[OFF_SUM_LAST] = CHAR_NUL;
                end
                default:
                begin
                    put_octal(OFF_SUM_FIRST, 7, 64'(csum));
                    hdr_blk[OFF_SUM_LAST] = CHAR_NUL;
                end
            endcase
            if (style == HS_NULSUM)
                hdr_blk[OFF_SUM_FIRST] = CHAR_NUL;
            if (style == HS_CORRUPT)
            begin
                pos = $urandom_range(0, 99);
                hdr_blk[pos] ^= 8'($urandom_range(1, 255));
            end
        end

        for (i = 0; i < BLOCK_BYTES; i++)
            emit(hdr_blk[i]);
        tr = '0;
        tr.kind = kd;
        if (kd == KIND_ACCEPT)
        begin
            tr.entry_size = size;
            tr.entry_type = tch;
        end
        stim[stim.size() - 1].typed = typed;
        stim[stim.size() - 1].typed_has = has;
        stim[stim.size() - 1].typed_rec = tr;

        if (with_body && style == HS_GOOD && size != 0)
        begin
            pad = 9'd0 - size[8:0];
            for (n = 0; n < 64'(size) + 64'(pad); n++)
                emit(8'($urandom));
        end
    endfunction

    // Each side either idles a random number of cycles per request or runs flat out
    // for a stretch.
    function automatic int unsigned draw_wait(inout int unsigned left, inout bit calm);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(16, 160);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Archive sender.
    initial
    begin
        int unsigned idx;
        int unsigned w;
        int unsigned tx_left;
        bit          tx_calm;
        int unsigned first_random;
        int unsigned entries;
        int unsigned r;
        hdr_style_t  style;
        size_form_t  form;
        logic [7:0]  tch;
        logic [35:0] size;

        tx_left = 0;
        tx_calm = 1'b0;
        dir_rows = '{
            '{HS_GOOD,     CH_REGULAR, 36'd5,     SF_STD,   1'b1, 1'b1, KIND_ACCEPT},
            '{HS_GOOD,     CH_FOLDER,  36'd0,     SF_STD,   1'b1, 1'b1, KIND_ACCEPT},
            '{HS_GOOD,     CH_REGULAR, 36'd512,   SF_STD,   1'b1, 1'b1, KIND_ACCEPT},
            '{HS_GOOD,     CHAR_LNAME, 36'd20,    SF_STD,   1'b1, 1'b0, KIND_DATA},
            '{HS_GOOD,     CHAR_LLINK, 36'd3,     SF_STD,   1'b1, 1'b0, KIND_DATA},
            '{HS_GOOD,     CHAR_LNAME, 36'd0,     SF_STD,   1'b1, 1'b0, KIND_DATA},
            '{HS_BADSUM,   CH_REGULAR, 36'd7,     SF_STD,   1'b1, 1'b1, KIND_REJECT},
            '{HS_BADMAGIC, CH_REGULAR, 36'd7,     SF_STD,   1'b1, 1'b1, KIND_REJECT},
            '{HS_CORRUPT,  CH_REGULAR, 36'd4,     SF_STD,   1'b1, 1'b1, KIND_REJECT},
            '{HS_NULSUM,   CH_REGULAR, 36'd7,     SF_STD,   1'b1, 1'b0, KIND_DATA},
            '{HS_ZERO,     8'h00,      36'd0,     SF_STD,   1'b1, 1'b0, KIND_DATA},
            '{HS_GOOD,     CH_REGULAR, 36'd9,     SF_SPACE, 1'b0, 1'b0, KIND_DATA},
            '{HS_GOOD,     CH_REGULAR, 36'o1234,  SF_JUNK,  1'b0, 1'b0, KIND_DATA},
            '{HS_GOOD,     8'hFF,      36'd0,     SF_STD,   1'b1, 1'b1, KIND_ACCEPT},
            '{HS_GOOD,     8'h00,      36'd1,     SF_STD,   1'b1, 1'b1, KIND_ACCEPT},
            '{HS_GOOD,     CH_REGULAR, 36'd1000,  SF_STD,   1'b0, 1'b0, KIND_DATA},
            '{HS_GOOD,     CH_REGULAR, 36'd511,   SF_STD,   1'b0, 1'b0, KIND_DATA}
        };
        foreach (dir_rows[i])
            add_entry(dir_rows[i].style, dir_rows[i].tchar, dir_rows[i].size,
                      dir_rows[i].form, dir_rows[i].typed, dir_rows[i].has,
                      dir_rows[i].kd, 1'b1);

        // Mostly well-formed entries with random content, the rest broken or noise.
        first_random = stim.size();
        entries = 0;
        while (stim.size() - first_random < RANDOM_BYTES || entries < RANDOM_ENTRIES)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: tch = CH_REGULAR;
                    5:             tch = CH_FOLDER;
                    6:             tch = CHAR_LNAME;
                    7:             tch = CHAR_LLINK;
                    default:       tch = 8'($urandom);
                endcase
                case ($urandom_range(0, 19))
                    0, 1:                         size = '0;
                    2, 3, 4, 5, 6, 7, 8, 9, 10, 11: size = 36'($urandom_range(1, 40));
                    12, 13, 14, 15, 16:           size = 36'($urandom_range(41, 700));
                    17:                           size = 36'd512;
                    18:                           size = 36'd1024;
                    default:                      size = 36'($urandom_range(0, 1) ? 511 : 513);
                endcase
                r = $urandom_range(0, 6);
                form = (r == 5) ? SF_SPACE : (r == 6) ? SF_JUNK : SF_STD;
                add_entry(HS_GOOD, tch, size, form, 1'b0, 1'b0, KIND_DATA, 1'b1);
            end
            else
            begin
                style = (r < 76) ? HS_BADSUM : (r < 82) ? HS_BADMAGIC :
                        (r < 88) ? HS_CORRUPT : (r < 92) ? HS_NULSUM :
                        (r < 95) ? HS_ZERO : HS_NOISE;
                size = {4'($urandom), 32'($urandom)};
                form = $urandom_range(0, 1) ? SF_STD : SF_FULL;
                add_entry(style, 8'($urandom), size, form, 1'b0, 1'b0, KIND_DATA, 1'b1);
            end
            entries++;
        end
        stim[first_random].hold = 1'b1;

        // Largest possible size, last in the run: only the start of its body is sent.
        add_entry(HS_GOOD, CH_REGULAR, '1, SF_FULL, 1'b1, 1'b1, KIND_ACCEPT, 1'b0);
        repeat (6) emit(8'($urandom));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < stim.size(); idx++)
        begin
            w = draw_wait(tx_left, tx_calm);
            if (stim[idx].hold || w > 0)
            begin
                byte_valid <= 1'b0;
                // Step past the pending clock edge first, so the request taken at it is already queued.
                if (stim[idx].hold)
                begin
                    @(posedge clk);
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
                repeat (w) @(posedge clk);
            end
            byte_valid <= 1'b1;
            data_byte <= stim[idx].data;
            do
                @(posedge clk);
            while (byte_stall);
        end
        byte_valid <= 1'b0;

        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d archive bytes: %0d headers accepted, %0d rejected,",
                 taken, n_accept, n_reject);
        $display("%0d payload bytes checked, %0d mismatches.", n_payload, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result receiver.
    initial
    begin
        int unsigned w;
        int unsigned rx_left;
        bit          rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            w = draw_wait(rx_left, rx_calm);
            if (w > 0)
            begin
                res_stall <= 1'b1;
                repeat (w) @(posedge clk);
                res_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // Both handshakes are observed at the clock edge, before any driver update.
    arch_item_t cur;
    rec_t       mon_rec;
    rec_t       want;
    bit         mon_has;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                cur = stim[taken];
                taken++;
                mon_has = deframe_byte(cur.data, mon_rec);
                if (cur.typed)
                begin
                    mon_has = cur.typed_has;
                    mon_rec = cur.typed_rec;
                end
                if (mon_has)
                    expected_q.push_back(mon_rec);
            end
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result kind=%0d byte=%h size=%0d %s",
                                 $realtime, kind, payload_byte, entry_size,
                                 $sformatf("type=%h last=%b", entry_type, last_of_run));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (kind !== want.kind || payload_byte !== want.payload_byte ||
                        entry_size !== want.entry_size || entry_type !== want.entry_type ||
                        last_of_run !== want.last_of_run)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch, expected kind=%0d byte=%h size=%0d %s",
                                     $realtime, want.kind, want.payload_byte,
                                     want.entry_size,
                                     $sformatf("type=%h last=%b", want.entry_type,
                                               want.last_of_run));
                            $display("%0t:           actual kind=%0d byte=%h size=%0d %s",
                                     $realtime, kind, payload_byte, entry_size,
                                     $sformatf("type=%h last=%b", entry_type,
                                               last_of_run));
                        end
                    end
                    if (want.kind == KIND_ACCEPT)
                        n_accept++;
                    else if (want.kind == KIND_REJECT)
                        n_reject++;
                    else
                        n_payload++;
                end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
